@@ hw/rtl/ola_pkg.sv @@
// Ordered array list: shared types, codes and sizing constants.
// Used by ola_seq and ordered_array_list_core; depends on nothing.
package ola_pkg;

  localparam int CAPACITY = 128;
  localparam int AW       = $clog2(CAPACITY);
  localparam int CNT_W    = 8;
  localparam int DW       = 32;

  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_DELETE = 3'd1;
  localparam logic [2:0] OP_READ   = 3'd2;
  localparam logic [2:0] OP_LOCATE = 3'd3;
  localparam logic [2:0] OP_PREV   = 3'd4;
  localparam logic [2:0] OP_NEXT   = 3'd5;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BADPOS = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_MISS   = 2'd3;

  typedef struct packed {
    logic [2:0]          opcode;
    logic [7:0]          position;
    logic signed [DW-1:0] data_value;
  } ola_req_t;

  typedef struct packed {
    logic [1:0]           status;
    logic signed [DW-1:0] result_value;
    logic [7:0]           found_position;
    logic [CNT_W-1:0]     list_length;
  } ola_res_t;

endpackage

@@ hw/rtl/ola_seq.sv @@
// Ordered array list sequencer: element memory, length register and the
// read-modify-write walks for insert, delete, read and the searches.
// Depends on ola_pkg.
module ola_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              req_valid,
  output logic              req_ready,
  input  ola_pkg::ola_req_t req,
  output logic              res_valid,
  input  logic              res_ready,
  output ola_pkg::ola_res_t res
);

  localparam int AW    = ola_pkg::AW;
  localparam int CNT_W = ola_pkg::CNT_W;
  localparam int DW    = ola_pkg::DW;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INS   = 3'd1;
  localparam logic [2:0] S_INSWR = 3'd2;
  localparam logic [2:0] S_DEL1  = 3'd3;
  localparam logic [2:0] S_DEL   = 3'd4;
  localparam logic [2:0] S_RD    = 3'd5;
  localparam logic [2:0] S_SCAN  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [DW-1:0] mem [ola_pkg::CAPACITY];
  logic [DW-1:0] rd_data_r;
  logic          we;
  logic [AW-1:0] wa, ra;
  logic [DW-1:0] wd;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [2:0]       op_r, op_nxt;
  logic [AW-1:0]    pos0_r, pos0_nxt;
  logic [DW-1:0]    val_r, val_nxt;
  logic [AW-1:0]    idx_r, idx_nxt;
  logic [DW-1:0]    prev_r, prev_nxt;
  logic [1:0]       status_r, status_nxt;
  logic [DW-1:0]    rv_r, rv_nxt;
  logic [7:0]       fp_r, fp_nxt;

  logic [CNT_W:0]   pos_x, cnt_x;
  logic [CNT_W-1:0] idx_x;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_r <= mem[ra];
  end

  assign pos_x = {1'b0, req.position};
  assign cnt_x = {1'b0, count_r};
  assign idx_x = CNT_W'(idx_r);

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    op_nxt     = op_r;
    pos0_nxt   = pos0_r;
    val_nxt    = val_r;
    idx_nxt    = idx_r;
    prev_nxt   = prev_r;
    status_nxt = status_r;
    rv_nxt     = rv_r;
    fp_nxt     = fp_r;
    we         = 1'b0;
    wa         = '0;
    wd         = '0;
    ra         = '0;
    case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          op_nxt     = req.opcode;
          pos0_nxt   = AW'(req.position - 8'd1);
          val_nxt    = req.data_value;
          status_nxt = ola_pkg::ST_OK;
          rv_nxt     = '0;
          fp_nxt     = '0;
          prev_nxt   = '0;
          state_nxt  = S_DONE;
          case (req.opcode)
            ola_pkg::OP_INSERT: begin
              if (req.position == 8'd0 || pos_x > cnt_x + 9'd1) begin
                status_nxt = ola_pkg::ST_BADPOS;
              end else if (count_r == CNT_W'(ola_pkg::CAPACITY)) begin
                status_nxt = ola_pkg::ST_FULL;
              end else if (pos_x == cnt_x + 9'd1) begin
                we        = 1'b1;
                wa        = AW'(req.position - 8'd1);
                wd        = req.data_value;
                count_nxt = count_r + 8'd1;
              end else begin
                ra        = AW'(count_r - 8'd1);
                idx_nxt   = AW'(count_r - 8'd1);
                state_nxt = S_INS;
              end
            end
            ola_pkg::OP_DELETE, ola_pkg::OP_READ: begin
              if (req.position == 8'd0 || pos_x > cnt_x) begin
                status_nxt = ola_pkg::ST_BADPOS;
              end else begin
                ra        = AW'(req.position - 8'd1);
                idx_nxt   = AW'(req.position - 8'd1);
                state_nxt = (req.opcode == ola_pkg::OP_DELETE) ? S_DEL1 : S_RD;
              end
            end
            ola_pkg::OP_LOCATE, ola_pkg::OP_PREV, ola_pkg::OP_NEXT: begin
              if (count_r == '0) begin
                status_nxt = ola_pkg::ST_MISS;
              end else begin
                ra        = '0;
                idx_nxt   = '0;
                state_nxt = S_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      S_INS: begin
        // move element idx up one place
        we = 1'b1;
        wa = idx_r + AW'(1);
        wd = rd_data_r;
        if (idx_r == pos0_r) begin
          state_nxt = S_INSWR;
        end else begin
          ra      = idx_r - AW'(1);
          idx_nxt = idx_r - AW'(1);
        end
      end
      S_INSWR: begin
        we        = 1'b1;
        wa        = pos0_r;
        wd        = val_r;
        count_nxt = count_r + 8'd1;
        state_nxt = S_DONE;
      end
      S_DEL1: begin
        rv_nxt = rd_data_r;
        if (idx_x + 8'd1 == count_r) begin
          count_nxt = count_r - 8'd1;
          state_nxt = S_DONE;
        end else begin
          ra        = idx_r + AW'(1);
          state_nxt = S_DEL;
        end
      end
      S_DEL: begin
        // move element idx+1 down one place
        we      = 1'b1;
        wa      = idx_r;
        wd      = rd_data_r;
        idx_nxt = idx_r + AW'(1);
        if (idx_x + 8'd2 == count_r) begin
          count_nxt = count_r - 8'd1;
          state_nxt = S_DONE;
        end else begin
          ra = idx_r + AW'(2);
        end
      end
      S_RD: begin
        rv_nxt    = rd_data_r;
        state_nxt = S_DONE;
      end
      S_SCAN: begin
        if (rd_data_r == val_r) begin
          fp_nxt    = idx_x + 8'd1;
          state_nxt = S_DONE;
          if (op_r == ola_pkg::OP_PREV) begin
            if (idx_r == '0) begin
              status_nxt = ola_pkg::ST_MISS;
            end else begin
              rv_nxt = prev_r;
            end
          end else if (op_r == ola_pkg::OP_NEXT) begin
            if (idx_x + 8'd1 < count_r) begin
              ra        = idx_r + AW'(1);
              state_nxt = S_RD;
            end else begin
              status_nxt = ola_pkg::ST_MISS;
            end
          end
        end else begin
          prev_nxt = rd_data_r;
          if (idx_x + 8'd1 == count_r) begin
            status_nxt = ola_pkg::ST_MISS;
            state_nxt  = S_DONE;
          end else begin
            ra      = idx_r + AW'(1);
            idx_nxt = idx_r + AW'(1);
          end
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    pos0_r   <= pos0_nxt;
    val_r    <= val_nxt;
    idx_r    <= idx_nxt;
    prev_r   <= prev_nxt;
    status_r <= status_nxt;
    rv_r     <= rv_nxt;
    fp_r     <= fp_nxt;
  end

  assign req_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res.status         = status_r;
  assign res.result_value   = rv_r;
  assign res.found_position = fp_r;
  assign res.list_length    = count_r;

endmodule

@@ hw/rtl/ordered_array_list_core.sv @@
// Ordered array list top level: word handshakes and the result register.
// Depends on ola_pkg and ola_seq.
//
// A list of up to 128 signed 32-bit elements kept in a memory with one
// read and one write per cycle, read data registered. One request is
// worked on at a time. With n the length and p the position, read fetches
// element p; insert writes at once when appending, else moves elements n
// down to p up one place and then writes; delete moves the elements after
// p down one place; locate, previous and next scan from the first element;
// rejected requests and unused opcodes give their result directly. The
// memory walk moves or compares one element per cycle. The next request is
// taken once the result word has left the sequencer, while it may still
// wait in the output register. No clearing pass follows reset.
module ordered_array_list_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          in_opcode,
  input  logic [7:0]          in_position,
  input  logic signed [31:0]  in_data_value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_status,
  output logic signed [31:0]  out_result_value,
  output logic [7:0]          out_found_position,
  output logic [7:0]          out_list_length
);

  ola_pkg::ola_req_t req;
  ola_pkg::ola_res_t res;
  ola_pkg::ola_res_t out_r;
  logic              req_ready;
  logic              res_valid;
  logic              res_ready;
  logic              out_valid_r;

  assign req.opcode     = in_opcode;
  assign req.position   = in_position;
  assign req.data_value = in_data_value;
  assign in_stall       = !req_ready;

  ola_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_valid),
    .req_ready (req_ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_r.status;
  assign out_result_value   = out_r.result_value;
  assign out_found_position = out_r.found_position;
  assign out_list_length    = out_r.list_length;

endmodule
